// ===== sv/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg: shared types and constants for the SSIM map combine block
// Field widths, register indexes, reset values and the structs that carry
// items between the front end, the divider and the output stage.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int MEAN_W   = 16;
    localparam int MOMENT_W = 24;
    localparam int CONST_W  = 24;
    localparam int RES_W    = 16;
    localparam int CFG_ADDR_W = 8;

    // Exact signed products of the numerator and denominator factors.
    localparam int PROD_W = 54;
    // Unsigned width of the divider remainder and divisor.
    localparam int DIV_W  = 53;
    // Quotient bits produced by the long division.
    localparam int QUOT_W = 16;

    localparam int S_TDATA_W = 104;

    localparam logic [CFG_ADDR_W-1:0] REG_STAB_C1 = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STAB_C2 = 8'd1;

    localparam logic [CONST_W-1:0] STAB_C1_RESET = 24'd1665;
    localparam logic [CONST_W-1:0] STAB_C2_RESET = 24'd14982;

    localparam logic [RES_W-1:0] ONE_Q15  = 16'd32768;
    localparam logic [RES_W-1:0] ZERO_Q15 = 16'd0;

    typedef struct packed {
        logic                     valid;
        logic signed [PROD_W-1:0] num;
        logic signed [PROD_W-1:0] den;
    } smc_frac_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] dissim;
        logic             degen;
    } smc_res_t;

endpackage

// ===== sv/smc_front.sv =====
// ----------------------------------------------------------------------------
// smc_front: moment combination and SSIM numerator and denominator
// Four stages: mean products, rounding to Q.8, factor sums, and the two
// wide signed products that form the numerator and the denominator.
// ----------------------------------------------------------------------------
module smc_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   ce,
    input  logic                                   in_valid,
    input  logic [smc_pkg::MEAN_W-1:0]             mean_a,
    input  logic [smc_pkg::MEAN_W-1:0]             mean_b,
    input  logic [smc_pkg::MOMENT_W-1:0]           moment_aa,
    input  logic [smc_pkg::MOMENT_W-1:0]           moment_bb,
    input  logic [smc_pkg::MOMENT_W-1:0]           moment_ab,
    input  logic [smc_pkg::CONST_W-1:0]            stab_c1,
    input  logic [smc_pkg::CONST_W-1:0]            stab_c2,
    output smc_pkg::smc_frac_t                     frac
);
    import smc_pkg::*;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    logic [31:0] p_aa_reg, p_bb_reg, p_ab_reg;
    logic [31:0] p_aa_next, p_bb_next, p_ab_next;
    logic [MOMENT_W-1:0] s1_eaa_reg, s1_ebb_reg, s1_eab_reg;

    logic [23:0] sq_a_reg, sq_b_reg, pab_reg;
    logic [24:0] pab2_reg;
    logic [23:0] sq_a_next, sq_b_next, pab_next;
    logic [24:0] pab2_next;
    logic [31:0] rnd_aa, rnd_bb, rnd_ab;
    logic [32:0] rnd_ab2;
    logic [MOMENT_W-1:0] s2_eaa_reg, s2_ebb_reg, s2_eab_reg;

    logic [25:0]        f1_reg, g1_reg, f1_next, g1_next;
    logic signed [26:0] f2_reg, g2_reg, f2_next, g2_next;

    logic signed [PROD_W-1:0] num_reg, den_reg, num_next, den_next;

    always_comb begin
        p_aa_next = mean_a * mean_a;
        p_bb_next = mean_b * mean_b;
        p_ab_next = mean_a * mean_b;
    end

    always_comb begin
        rnd_aa    = p_aa_reg + 32'd128;
        rnd_bb    = p_bb_reg + 32'd128;
        rnd_ab    = p_ab_reg + 32'd128;
        rnd_ab2   = {p_ab_reg, 1'b0} + 33'd128;
        sq_a_next = rnd_aa[31:8];
        sq_b_next = rnd_bb[31:8];
        pab_next  = rnd_ab[31:8];
        pab2_next = rnd_ab2[32:8];
    end

    always_comb begin
        f1_next = {1'b0, pab2_reg} + {2'b00, stab_c1};
        g1_next = {2'b00, sq_a_reg} + {2'b00, sq_b_reg} + {2'b00, stab_c1};
        f2_next = $signed({2'b00, s2_eab_reg, 1'b0}) - $signed({2'b00, pab_reg, 1'b0})
                + $signed({3'b000, stab_c2});
        g2_next = $signed({3'b000, s2_eaa_reg}) + $signed({3'b000, s2_ebb_reg})
                + $signed({3'b000, stab_c2}) - $signed({3'b000, sq_a_reg})
                - $signed({3'b000, sq_b_reg});
    end

    always_comb begin
        num_next = $signed({1'b0, f1_reg}) * f2_reg;
        den_next = $signed({1'b0, g1_reg}) * g2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_aa_reg   <= p_aa_next;
            p_bb_reg   <= p_bb_next;
            p_ab_reg   <= p_ab_next;
            s1_eaa_reg <= moment_aa;
            s1_ebb_reg <= moment_bb;
            s1_eab_reg <= moment_ab;

            sq_a_reg   <= sq_a_next;
            sq_b_reg   <= sq_b_next;
            pab_reg    <= pab_next;
            pab2_reg   <= pab2_next;
            s2_eaa_reg <= s1_eaa_reg;
            s2_ebb_reg <= s1_ebb_reg;
            s2_eab_reg <= s1_eab_reg;

            f1_reg     <= f1_next;
            f2_reg     <= f2_next;
            g1_reg     <= g1_next;
            g2_reg     <= g2_next;

            num_reg    <= num_next;
            den_reg    <= den_next;
        end
    end

    assign frac.valid = s4_valid_reg;
    assign frac.num   = num_reg;
    assign frac.den   = den_reg;

endmodule

// ===== sv/smc_divide.sv =====
// ----------------------------------------------------------------------------
// smc_divide: sign fix, special cases and pipelined long division
// Normalizes the denominator sign, sorts out the degenerate and clamped
// cases, then produces one quotient bit per stage and rounds to Q1.15.
// ----------------------------------------------------------------------------
module smc_divide (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  smc_pkg::smc_frac_t  frac,
    output smc_pkg::smc_res_t   res
);
    import smc_pkg::*;

    logic                     s5_valid_reg;
    logic signed [PROD_W-1:0] s5_num_reg, s5_den_reg, s5_num_next, s5_den_next;
    logic                     s5_zero_reg, s5_zero_next;

    logic signed [PROD_W-1:0] diff;
    logic                     force_next, degen_next;
    logic [RES_W-1:0]         fval_next;

    logic                     valid_reg [0:QUOT_W];
    logic [DIV_W-1:0]         rem_reg   [0:QUOT_W];
    logic [DIV_W-1:0]         dv_reg    [0:QUOT_W];
    logic [QUOT_W-1:0]        q_reg     [0:QUOT_W];
    logic                     force_reg [0:QUOT_W];
    logic [RES_W-1:0]         fval_reg  [0:QUOT_W];
    logic                     degen_reg [0:QUOT_W];

    logic [QUOT_W:0]          q_round;
    logic [RES_W-1:0]         dissim_next;
    smc_res_t                 res_reg;

    always_comb begin
        s5_zero_next = (frac.den == '0);
        if (frac.den < 0) begin
            s5_num_next = -frac.num;
            s5_den_next = -frac.den;
        end else begin
            s5_num_next = frac.num;
            s5_den_next = frac.den;
        end
    end

    always_comb begin
        diff       = s5_den_reg - s5_num_reg;
        force_next = 1'b1;
        degen_next = 1'b0;
        fval_next  = ONE_Q15;
        if (s5_zero_reg) begin
            degen_next = 1'b1;
        end else if (s5_num_reg >= s5_den_reg) begin
            fval_next = ZERO_Q15;
        end else if (s5_num_reg <= 0) begin
            fval_next = ONE_Q15;
        end else begin
            force_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
            valid_reg[0] <= 1'b0;
        end else if (ce) begin
            s5_valid_reg <= frac.valid;
            valid_reg[0] <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s5_num_reg   <= s5_num_next;
            s5_den_reg   <= s5_den_next;
            s5_zero_reg  <= s5_zero_next;
            rem_reg[0]   <= diff[DIV_W-1:0];
            dv_reg[0]    <= s5_den_reg[DIV_W-1:0];
            q_reg[0]     <= '0;
            force_reg[0] <= force_next;
            fval_reg[0]  <= fval_next;
            degen_reg[0] <= degen_next;
        end
    end

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
        logic [DIV_W-1:0]  shifted;
        logic [DIV_W-1:0]  rem_next;
        logic              bit_next;

        always_comb begin
            shifted  = {rem_reg[k-1][DIV_W-2:0], 1'b0};
            bit_next = (shifted >= dv_reg[k-1]);
            rem_next = bit_next ? (shifted - dv_reg[k-1]) : shifted;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ce) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]   <= rem_next;
                dv_reg[k]    <= dv_reg[k-1];
                q_reg[k]     <= {q_reg[k-1][QUOT_W-2:0], bit_next};
                force_reg[k] <= force_reg[k-1];
                fval_reg[k]  <= fval_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    always_comb begin
        q_round = {1'b0, q_reg[QUOT_W]} + {{QUOT_W{1'b0}}, 1'b1};
        if (force_reg[QUOT_W]) begin
            dissim_next = fval_reg[QUOT_W];
        end else if (q_round[QUOT_W:1] > ONE_Q15) begin
            dissim_next = ONE_Q15;
        end else begin
            dissim_next = q_round[QUOT_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (ce) begin
            res_reg.valid <= valid_reg[QUOT_W];
        end
        if (ce) begin
            res_reg.dissim <= dissim_next;
            res_reg.degen  <= degen_reg[QUOT_W];
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/smc_skid.sv =====
// ----------------------------------------------------------------------------
// smc_skid: output register with skid buffer
// Holds the result beat for the receiver and parks one more beat while the
// receiver stalls, so the pipeline enable comes straight from a register.
// ----------------------------------------------------------------------------
module smc_skid (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smc_pkg::smc_res_t             res,
    output logic                          ce,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smc_pkg::RES_W-1:0]     m_tdata,
    output logic                          m_tuser
);
    import smc_pkg::*;

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    smc_res_t out_reg, out_next;
    smc_res_t skid_reg, skid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = res;
                out_valid_next = res.valid;
            end
        end else if (res.valid && !skid_valid_reg) begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign ce       = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.dissim;
    assign m_tuser  = out_reg.degen;

endmodule

// ===== sv/ssim_map_combine.sv =====
// ----------------------------------------------------------------------------
// ssim_map_combine: per-pixel SSIM dissimilarity map combine
// Takes local means and second moments of two images and returns
// 1 - SSIM in Q1.15, clamped to [0,1], with a flag for a zero denominator.
// ----------------------------------------------------------------------------
// Each input beat on the s_ channel carries one pixel's two means and three
// moments; each output beat on the m_ channel carries its dissimilarity in
// m_tdata and the degenerate flag in m_tuser. The stabilizing constants must be
// written through the cfg_ channel while no pixel is in flight; the block does
// not enforce it; cfg_ready is always high, and an index above 1 is ignored.
// The block takes one beat per clock while s_tready is high. On the way from an
// accepted input beat to m_tvalid, four stages form the numerator and
// denominator, two resolve sign and special cases, sixteen stages each yield
// one quotient bit of the long division, and one rounds the quotient ahead of
// the output register.
// Reset clears all valid bits and loads the default constants.
// When the receiver stalls, the output register holds its beat and a skid
// register takes the next one; s_tready then drops and the whole pipeline
// holds until the receiver takes the waiting beat.
// ----------------------------------------------------------------------------
module ssim_map_combine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mean_a, mean_b, moment_aa, moment_bb, moment_ab
    input  logic [smc_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // dissimilarity
    output logic [smc_pkg::RES_W-1:0]          m_tdata,
    // degenerate
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [smc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [smc_pkg::CONST_W-1:0]        cfg_wdata
);
    import smc_pkg::*;

    logic [CONST_W-1:0] stab_c1_reg, stab_c1_next;
    logic [CONST_W-1:0] stab_c2_reg, stab_c2_next;
    logic               ce;
    smc_frac_t          frac;
    smc_res_t           res;

    always_comb begin
        stab_c1_next = stab_c1_reg;
        stab_c2_next = stab_c2_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                REG_STAB_C1: stab_c1_next = cfg_wdata;
                REG_STAB_C2: stab_c2_next = cfg_wdata;
                default: begin
                    stab_c1_next = stab_c1_reg;
                    stab_c2_next = stab_c2_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stab_c1_reg <= STAB_C1_RESET;
            stab_c2_reg <= STAB_C2_RESET;
        end else begin
            stab_c1_reg <= stab_c1_next;
            stab_c2_reg <= stab_c2_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = ce;

    smc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .mean_a    (s_tdata[15:0]),
        .mean_b    (s_tdata[31:16]),
        .moment_aa (s_tdata[55:32]),
        .moment_bb (s_tdata[79:56]),
        .moment_ab (s_tdata[103:80]),
        .stab_c1   (stab_c1_reg),
        .stab_c2   (stab_c2_reg),
        .frac      (frac)
    );

    smc_divide u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .frac    (frac),
        .res     (res)
    );

    smc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .ce       (ce),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    a_degen_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == ONE_Q15))
        else $error("degenerate result is not 1.0");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= ONE_Q15))
        else $error("dissimilarity above 1.0");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && $past(aresetn)) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready) |-> m_tvalid)
        else $error("skid beat parked while output register empty");
`endif

endmodule

// ===== bench/tb_ssim_map_combine.sv =====
// ----------------------------------------------------------------------------
// tb_ssim_map_combine: self-checking testbench for the SSIM map combine block
// Drives pixel statistics into the stream input, predicts each dissimilarity
// and degenerate flag in fixed point, and compares every output beat in order.
// Covers corner pixels, constant extremes, ignored register writes, random
// traffic under three idle patterns, and a long output stall.
// ----------------------------------------------------------------------------
module tb_ssim_map_combine;
    import smc_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED     = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_TOP = 8'hFF;
    localparam longint MOMENT_MAX = 64'hFF_FFFF;

    typedef struct packed {
        logic [MOMENT_W-1:0] moment_ab;
        logic [MOMENT_W-1:0] moment_bb;
        logic [MOMENT_W-1:0] moment_aa;
        logic [MEAN_W-1:0]   mean_b;
        logic [MEAN_W-1:0]   mean_a;
    } pixel_t;

    typedef struct packed {
        logic [RES_W-1:0] dissim;
        logic             degen;
    } dissim_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [RES_W-1:0]       m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CONST_W-1:0]     cfg_wdata = '0;

    logic [CONST_W-1:0] stab_c1_model = STAB_C1_RESET;
    logic [CONST_W-1:0] stab_c2_model = STAB_C2_RESET;
    dissim_t            pending_dissim[$];
    int                 send_idle_pct = 9;
    int                 recv_idle_pct = 76;
    int                 hold_left     = 0;
    int                 error_count   = 0;
    int                 result_count  = 0;
    int                 cycle_count   = 0;

    ssim_map_combine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic dissim_t predict_dissimilarity(input pixel_t px,
                                                      input logic [CONST_W-1:0] c1,
                                                      input logic [CONST_W-1:0] c2);
        longint  ma, mb, eaa, ebb, eab, k1, k2;
        longint  sq_a, sq_b, pab, pab2, va, vb, cov;
        longint  num, den, d, rem, quot;
        int      bit_idx;
        dissim_t r;
        ma   = longint'(px.mean_a);
        mb   = longint'(px.mean_b);
        eaa  = longint'(px.moment_aa);
        ebb  = longint'(px.moment_bb);
        eab  = longint'(px.moment_ab);
        k1   = longint'(c1);
        k2   = longint'(c2);
        sq_a = (ma * ma + 128) >>> 8;
        sq_b = (mb * mb + 128) >>> 8;
        pab  = (ma * mb + 128) >>> 8;
        pab2 = (2 * ma * mb + 128) >>> 8;
        va   = eaa - sq_a;
        vb   = ebb - sq_b;
        cov  = eab - pab;
        num  = (pab2 + k1) * (2 * cov + k2);
        den  = (sq_a + sq_b + k1) * (va + vb + k2);
        r.degen = 1'b0;
        if (den == 0) begin
            r.dissim = ONE_Q15;
            r.degen  = 1'b1;
        end else begin
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            d = den - num;
            if (d <= 0) begin
                r.dissim = ZERO_Q15;
            end else if (d >= den) begin
                r.dissim = ONE_Q15;
            end else begin
                rem  = d;
                quot = 0;
                for (bit_idx = 0; bit_idx < 16; bit_idx++) begin
                    rem  = rem <<< 1;
                    quot = quot <<< 1;
                    if (rem >= den) begin
                        rem  = rem - den;
                        quot = quot | 1;
                    end
                end
                quot = (quot + 1) >>> 1;
                r.dissim = (quot > longint'(ONE_Q15)) ? ONE_Q15 : quot[RES_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [MOMENT_W-1:0] clamp_moment(input longint v);
        if (v < 0)
            return '0;
        if (v > MOMENT_MAX)
            return '1;
        return v[MOMENT_W-1:0];
    endfunction

    function automatic pixel_t make_pixel(input longint ma, input longint mb,
                                          input longint eaa, input longint ebb,
                                          input longint eab);
        pixel_t px;
        px.mean_a    = ma[MEAN_W-1:0];
        px.mean_b    = mb[MEAN_W-1:0];
        px.moment_aa = clamp_moment(eaa);
        px.moment_bb = clamp_moment(ebb);
        px.moment_ab = clamp_moment(eab);
        return px;
    endfunction

    // Statistics that a real image window could produce; the broken variant
    // pushes the moment of A below its squared mean.
    function automatic pixel_t natural_pixel(input bit broken);
        longint ma, mb, va, vb, lim, cov;
        ma = longint'($urandom_range(65280));
        if ($urandom_range(1) == 1) begin
            mb = ma + longint'($urandom_range(1024)) - 512;
            if (mb < 0)
                mb = 0;
            if (mb > 65535)
                mb = 65535;
        end else begin
            mb = longint'($urandom_range(65280));
        end
        va  = longint'($urandom_range(1 << $urandom_range(4, 23)));
        vb  = longint'($urandom_range(1 << $urandom_range(4, 23)));
        lim = (va < vb) ? va : vb;
        cov = longint'($urandom_range(32'(2 * lim))) - lim;
        if (broken)
            va = -longint'($urandom_range(1 << $urandom_range(2, 20)));
        return make_pixel(ma, mb, ((ma * ma + 128) >>> 8) + va,
                          ((mb * mb + 128) >>> 8) + vb,
                          ((ma * mb + 128) >>> 8) + cov);
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("ERROR: beat %0d %s got %0d expected %0d", result_count, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        dissim_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dissim.size() == 0) begin
                report_mismatch("unexpected beat, dissimilarity", longint'(m_tdata),
                                longint'(-1));
            end else begin
                want = pending_dissim.pop_front();
                if (m_tdata !== want.dissim)
                    report_mismatch("dissimilarity", longint'(m_tdata),
                                    longint'(want.dissim));
                if (m_tuser !== want.degen)
                    report_mismatch("degenerate", longint'(m_tuser),
                                    longint'(want.degen));
            end
            result_count++;
        end
    end

    task automatic send_pixel(input pixel_t px);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        pending_dissim.push_back(predict_dissimilarity(px, stab_c1_model, stab_c2_model));
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CONST_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (addr == REG_STAB_C1)
            stab_c1_model = data;
        else if (addr == REG_STAB_C2)
            stab_c2_model = data;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_dissim.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_corner_pixels();
        send_pixel(make_pixel(0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 65535, MOMENT_MAX, MOMENT_MAX, MOMENT_MAX));
        send_pixel(make_pixel(25600, 25600, 2565000, 2565000, 2565000));
        send_pixel(make_pixel(25600, 25600, 2560000 - 14982, 2560000, 0));
        send_pixel(make_pixel(65280, 65280, 0, 0, 0));
        send_pixel(make_pixel(32768, 32768, 4594304, 4594304, 3794304));
        send_pixel(make_pixel(25600, 20000, 2559900, 1562500, 2000000));
        send_pixel(make_pixel(12800, 13056, 730000, 745856, 712800));
        send_pixel(make_pixel(65535, 0, MOMENT_MAX, 0, MOMENT_MAX));
        send_pixel(make_pixel(0, 65535, 0, MOMENT_MAX, 0));
        wait_idle();
    endtask

    task automatic test_constant_extremes();
        write_reg(REG_STAB_C1, '0);
        write_reg(REG_STAB_C2, '0);
        cfg_valid <= 1'b0;
        send_pixel(make_pixel(0, 0, 0, 0, 0));
        send_pixel(make_pixel(5, 5, MOMENT_MAX, MOMENT_MAX, MOMENT_MAX));
        send_pixel(make_pixel(12800, 13056, 730000, 745856, 712800));
        wait_idle();
        write_reg(REG_STAB_C1, '1);
        write_reg(REG_STAB_C2, '1);
        cfg_valid <= 1'b0;
        send_pixel(make_pixel(0, 0, 0, 0, 0));
        send_pixel(make_pixel(65535, 65535, MOMENT_MAX, MOMENT_MAX, MOMENT_MAX));
        send_pixel(make_pixel(12800, 13056, 730000, 745856, 712800));
        wait_idle();
    endtask

    task automatic test_reserved_index();
        write_reg(REG_STAB_C1, STAB_C1_RESET);
        write_reg(REG_STAB_C2, STAB_C2_RESET);
        write_reg(REG_UNUSED, 24'h00ABCD);
        write_reg(REG_UNUSED_TOP, '1);
        cfg_valid <= 1'b0;
        send_pixel(make_pixel(12800, 13056, 730000, 745856, 712800));
        send_pixel(make_pixel(25600, 25600, 2560000 - 14982, 2560000, 0));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct,
                                       input logic [CONST_W-1:0] c1,
                                       input logic [CONST_W-1:0] c2);
        int     n;
        int     pick;
        pixel_t px;
        write_reg(REG_STAB_C1, c1);
        write_reg(REG_STAB_C2, c2);
        cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                px = natural_pixel(1'b0);
            end else if (pick < 85) begin
                px = natural_pixel(1'b1);
            end else begin
                px.mean_a    = MEAN_W'($urandom);
                px.mean_b    = MEAN_W'($urandom);
                px.moment_aa = MOMENT_W'($urandom);
                px.moment_bb = MOMENT_W'($urandom);
                px.moment_ab = MOMENT_W'($urandom);
            end
            send_pixel(px);
        end
        wait_idle();
    endtask

    task automatic test_output_stall(input int count);
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        for (n = 0; n < count; n++)
            send_pixel(natural_pixel(1'b0));
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_pixels();
        test_constant_extremes();
        test_reserved_index();
        test_random_traffic(280, 9, 76, STAB_C1_RESET, STAB_C2_RESET);
        test_random_traffic(280, 76, 9, CONST_W'($urandom_range(65535)),
                            CONST_W'($urandom_range(200000)));
        test_random_traffic(230, 0, 0, CONST_W'($urandom), CONST_W'($urandom));
        test_output_stall(60);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== ssim_map_combine.f =====
sv/smc_pkg.sv
sv/smc_front.sv
sv/smc_divide.sv
sv/smc_skid.sv
sv/ssim_map_combine.sv
bench/tb_ssim_map_combine.sv
